### rtl/spl_pkg.sv
// Shared types and constants for the shelf packer with LRU pages.
// Used by every module of the block but spl_ram, and by its checker.
package spl_pkg;

  localparam int DEF_PAGE_SIZE = 1024;
  localparam int DEF_MAX_PAGES = 8;
  localparam int DIM_W         = 12;
  localparam int SUM_W         = 14;
  localparam int STAMP_W       = 64;
  localparam int TP_W          = 3;
  localparam int POS_W         = 10;
  localparam int CNT_CMP_W     = 7;

  typedef enum logic [0:0] {
    KIND_PLACE = 1'b0,
    KIND_TOUCH = 1'b1
  } spl_kind_e;

  typedef struct packed {
    spl_kind_e           kind;
    logic [DIM_W-1:0]    rect_width;
    logic [DIM_W-1:0]    rect_height;
    logic [TP_W-1:0]     touch_page;
    logic [STAMP_W-1:0]  use_stamp;
  } spl_req_t;

  typedef struct packed {
    logic             ok;
    logic [TP_W-1:0]  page_index;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             new_page;
    logic             evicted;
  } spl_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ROW,
    ST_HCHK,
    ST_ALLOC,
    ST_SCAN,
    ST_DRAIN,
    ST_EVICT,
    ST_PLACE
  } spl_state_e;

  typedef struct packed {
    logic load;
    logic rsp_touch;
    logic touch_wr;
    logic rsp_zero;
    logic adv_row;
    logic open_new;
    logic scan_start;
    logic scan_rd;
    logic open_evict;
    logic place;
  } spl_cmd_t;

  typedef struct packed {
    logic is_touch;
    logic touch_ok;
    logic size_ok;
    logic pvalid;
    logic row_fits;
    logic hfit;
    logic count_full;
    logic scan_last;
    logic best_use;
  } spl_sts_t;

endpackage

### rtl/spl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/spl_ctrl.sv
// Controller state machine of the shelf packer.
// Depends on spl_pkg; drives commands into spl_dp from its status.
module spl_ctrl import spl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  spl_sts_t sts_i,
  output spl_cmd_t cmd_o,
  output logic     busy_o
);

  spl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts_i.is_touch || !sts_i.size_ok) state_d = ST_IDLE;
        else if (sts_i.pvalid) state_d = ST_ROW;
        else state_d = ST_ALLOC;
      end
      ST_ROW:   state_d = ST_HCHK;
      ST_HCHK: begin
        state_d = sts_i.hfit ? ST_PLACE : ST_ALLOC;
      end
      ST_ALLOC: begin
        state_d = sts_i.count_full ? ST_SCAN : ST_PLACE;
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_EVICT;
      ST_EVICT: begin
        state_d = sts_i.best_use ? ST_IDLE : ST_PLACE;
      end
      ST_PLACE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_DECODE: begin
        if (sts_i.is_touch) begin
          cmd_o.rsp_touch = 1'b1;
          cmd_o.touch_wr  = sts_i.touch_ok;
        end else if (!sts_i.size_ok) begin
          cmd_o.rsp_zero = 1'b1;
        end
      end
      ST_ROW:   cmd_o.adv_row = !sts_i.row_fits;
      ST_HCHK:  cmd_o = '0;
      ST_ALLOC: begin
        cmd_o.scan_start = sts_i.count_full;
        cmd_o.open_new   = !sts_i.count_full;
      end
      ST_SCAN:  cmd_o.scan_rd = 1'b1;
      ST_DRAIN: cmd_o = '0;
      ST_EVICT: begin
        cmd_o.rsp_zero   = sts_i.best_use;
        cmd_o.open_evict = !sts_i.best_use;
      end
      ST_PLACE: cmd_o.place = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

endmodule

### rtl/spl_dp.sv
// Datapath of the shelf packer: request latch, shelf, page bookkeeping,
// LRU scan over the stamp RAM and result register. Depends on spl_pkg, spl_ram.
module spl_dp import spl_pkg::*; #(
  parameter int PAGE_SIZE = DEF_PAGE_SIZE,
  parameter int MAX_PAGES = DEF_MAX_PAGES
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spl_req_t req_i,
  input  spl_cmd_t cmd_i,
  output spl_sts_t sts_o,
  output spl_rsp_t rsp_o,
  output logic     done_o
);

  localparam int CW = $clog2(PAGE_SIZE + 1);
  localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int NW = $clog2(MAX_PAGES + 1);

  spl_req_t           req_q, req_d;
  logic [CW-1:0]      x_q, x_d, y_q, y_d, hgt_q, hgt_d;
  logic               pvalid_q, pvalid_d;
  logic [PW-1:0]      ppage_q, ppage_d;
  logic [NW-1:0]      cnt_q, cnt_d;
  logic [PW-1:0]      scan_addr_q, scan_addr_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [PW-1:0]      cmp_idx_q, cmp_idx_d;
  logic [PW-1:0]      best_idx_q, best_idx_d;
  logic [STAMP_W-1:0] best_age_q, best_age_d;
  logic               best_use_q, best_use_d;
  logic               fresh_q, fresh_d, evict_q, evict_d;
  spl_rsp_t           rsp_q, rsp_d;
  logic               done_q, done_d;

  logic [STAMP_W-1:0] rd_stamp;
  logic               rd_match;
  logic [STAMP_W-1:0] rd_age;
  logic [PW-1:0]      tp_addr;
  logic [PW-1:0]      wr_addr;
  logic [SUM_W-1:0]   w_ext, h_ext, x_sum, y_sum;

  assign w_ext   = SUM_W'(req_q.rect_width);
  assign h_ext   = SUM_W'(req_q.rect_height);
  assign x_sum   = SUM_W'(x_q) + w_ext + SUM_W'(1);
  assign y_sum   = SUM_W'(y_q) + h_ext + SUM_W'(1);
  assign tp_addr = PW'(req_q.touch_page);
  assign wr_addr = cmd_i.place ? ppage_q : tp_addr;

  spl_ram #(
    .WIDTH(STAMP_W),
    .DEPTH(MAX_PAGES)
  ) u_stamp_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.touch_wr | cmd_i.place),
    .waddr_i(wr_addr),
    .wdata_i(req_q.use_stamp),
    .raddr_i(scan_addr_q),
    .rdata_o(rd_stamp)
  );

  assign rd_match = (rd_stamp == req_q.use_stamp);
  assign rd_age   = rd_match ? '1 : rd_stamp;

  always_comb begin
    sts_o.is_touch   = (req_q.kind == KIND_TOUCH);
    sts_o.touch_ok   = CNT_CMP_W'(req_q.touch_page) < CNT_CMP_W'(cnt_q);
    sts_o.size_ok    = (req_q.rect_width != '0) && (req_q.rect_height != '0) &&
                       (w_ext <= SUM_W'(PAGE_SIZE - 2)) && (h_ext <= SUM_W'(PAGE_SIZE - 2));
    sts_o.pvalid     = pvalid_q;
    sts_o.row_fits   = (x_sum <= SUM_W'(PAGE_SIZE));
    sts_o.hfit       = (y_sum <= SUM_W'(PAGE_SIZE));
    sts_o.count_full = (cnt_q == NW'(MAX_PAGES));
    sts_o.scan_last  = (scan_addr_q == PW'(MAX_PAGES - 1));
    sts_o.best_use   = best_use_q;
  end

  always_comb begin
    req_d       = req_q;
    x_d         = x_q;
    y_d         = y_q;
    hgt_d       = hgt_q;
    pvalid_d    = pvalid_q;
    ppage_d     = ppage_q;
    cnt_d       = cnt_q;
    scan_addr_d = scan_addr_q;
    cmp_vld_d   = cmd_i.scan_rd;
    cmp_idx_d   = scan_addr_q;
    best_idx_d  = best_idx_q;
    best_age_d  = best_age_q;
    best_use_d  = best_use_q;
    fresh_d     = fresh_q;
    evict_d     = evict_q;
    rsp_d       = rsp_q;
    done_d      = 1'b0;

    if (cmd_i.load) begin
      req_d   = req_i;
      fresh_d = 1'b0;
      evict_d = 1'b0;
    end

    if (cmd_i.rsp_touch) begin
      rsp_d  = '0;
      done_d = 1'b1;
      if (sts_o.touch_ok) begin
        rsp_d.ok         = 1'b1;
        rsp_d.page_index = req_q.touch_page;
      end
    end

    if (cmd_i.rsp_zero) begin
      rsp_d  = '0;
      done_d = 1'b1;
    end

    if (cmd_i.adv_row) begin
      x_d   = CW'(1);
      y_d   = CW'(SUM_W'(y_q) + SUM_W'(hgt_q) + SUM_W'(1));
      hgt_d = '0;
    end

    if (cmd_i.open_new || cmd_i.open_evict) begin
      ppage_d  = cmd_i.open_new ? PW'(cnt_q) : best_idx_q;
      pvalid_d = 1'b1;
      x_d      = CW'(1);
      y_d      = CW'(1);
      hgt_d    = '0;
      fresh_d  = 1'b1;
      evict_d  = cmd_i.open_evict;
    end

    if (cmd_i.open_new) begin
      cnt_d = cnt_q + NW'(1);
    end

    if (cmd_i.scan_start) begin
      scan_addr_d = '0;
    end else if (cmd_i.scan_rd) begin
      scan_addr_d = scan_addr_q + PW'(1);
    end

    if (cmp_vld_q && ((cmp_idx_q == '0) || (rd_age < best_age_q))) begin
      best_idx_d = cmp_idx_q;
      best_age_d = rd_age;
      best_use_d = rd_match;
    end

    if (cmd_i.place) begin
      x_d = CW'(x_sum);
      if (h_ext > SUM_W'(hgt_q)) hgt_d = CW'(req_q.rect_height);
      rsp_d.ok         = 1'b1;
      rsp_d.page_index = TP_W'(ppage_q);
      rsp_d.pos_x      = POS_W'(x_q);
      rsp_d.pos_y      = POS_W'(y_q);
      rsp_d.new_page   = fresh_q;
      rsp_d.evicted    = evict_q;
      done_d           = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q         <= CW'(1);
      y_q         <= CW'(1);
      hgt_q       <= '0;
      pvalid_q    <= 1'b0;
      ppage_q     <= '0;
      cnt_q       <= '0;
      scan_addr_q <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      best_use_q  <= 1'b0;
      fresh_q     <= 1'b0;
      evict_q     <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      x_q         <= x_d;
      y_q         <= y_d;
      hgt_q       <= hgt_d;
      pvalid_q    <= pvalid_d;
      ppage_q     <= ppage_d;
      cnt_q       <= cnt_d;
      scan_addr_q <= scan_addr_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      best_use_q  <= best_use_d;
      fresh_q     <= fresh_d;
      evict_q     <= evict_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    best_idx_q <= best_idx_d;
    best_age_q <= best_age_d;
    rsp_q      <= rsp_d;
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

### rtl/shelf_packer_with_lru_pages.sv
// Top level of the shelf packer with LRU page eviction.
// Depends on spl_pkg, spl_ctrl, spl_dp (and spl_ram below it).
//
// A request is taken when start is high while busy is low; its result
// appears on rsp_o for one cycle with done_o, and the receiver cannot stall
// it. A touch or a rejected size is answered from the decode state, a
// placement on the open page after the shelf and height checks, the first
// placement after reset after page allocation, a placement that opens a new
// page after both, and one that must evict after an LRU scan: the eviction
// walks the page stamps one per cycle through the read port of the stamp RAM.
module shelf_packer_with_lru_pages import spl_pkg::*; #(
  parameter int PAGE_SIZE = DEF_PAGE_SIZE,
  parameter int MAX_PAGES = DEF_MAX_PAGES
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  spl_req_t req_i,
  output logic     done_o,
  output spl_rsp_t rsp_o
);

  spl_cmd_t cmd;
  spl_sts_t sts;

  spl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  spl_dp #(
    .PAGE_SIZE(PAGE_SIZE),
    .MAX_PAGES(MAX_PAGES)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (rsp_o),
    .done_o(done_o)
  );

endmodule

### rtl/spl_checker.sv
// Port-level checks for the shelf packer, bound to the top level.
// Depends on spl_pkg and shelf_packer_with_lru_pages.
module spl_checker import spl_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     busy,
  input logic     done_o,
  input spl_rsp_t rsp_o
);

  a_fail_all_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.ok |-> rsp_o == '0)
    else $error("failed request carries nonzero fields");

  a_evict_is_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.evicted |-> rsp_o.new_page)
    else $error("eviction without a new page");

  a_new_page_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.new_page |-> rsp_o.pos_x == POS_W'(1) && rsp_o.pos_y == POS_W'(1))
    else $error("new page placement not at the page origin");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a request in progress");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

endmodule

bind shelf_packer_with_lru_pages spl_checker u_spl_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);

### test/shelf_packer_checker.sv
`timescale 1ns / 1ps
// Checker for shelf_packer_with_lru_pages: watches requests and results,
// predicts each placement or touch and compares the results. Needs spl_pkg.
module shelf_packer_checker import spl_pkg::*; #(
  parameter int PAGE_SIZE = DEF_PAGE_SIZE,
  parameter int MAX_PAGES = DEF_MAX_PAGES
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     busy,
  input  spl_req_t req_i,
  input  logic     done_o,
  input  spl_rsp_t rsp_o,
  output int       fail_count,
  output int       pending
);

  int unsigned        pages_open;
  bit                 cur_valid;
  int unsigned        cur_page;
  int unsigned        row_x [MAX_PAGES];
  int unsigned        row_y [MAX_PAGES];
  int unsigned        row_h [MAX_PAGES];
  logic [STAMP_W-1:0] page_use [MAX_PAGES];

  spl_rsp_t slot_q [$];
  spl_rsp_t want;
  int       err_total;

  function automatic void clear_atlas();
    pages_open = 0;
    cur_valid  = 1'b0;
    cur_page   = 0;
    for (int i = 0; i < MAX_PAGES; i++) begin
      row_x[i]    = 1;
      row_y[i]    = 1;
      row_h[i]    = 0;
      page_use[i] = '0;
    end
  endfunction

  function automatic void open_fresh(input int unsigned pg, input logic [STAMP_W-1:0] use_s);
    row_x[pg]    = 1;
    row_y[pg]    = 1;
    row_h[pg]    = 0;
    page_use[pg] = use_s;
    cur_page     = pg;
    cur_valid    = 1'b1;
  endfunction

  // Create a page while there is room, else evict the oldest page not in use.
  function automatic bit claim_page(input logic [STAMP_W-1:0] use_s,
                                    output int unsigned pg, output bit by_evict);
    int unsigned        best;
    logic [STAMP_W-1:0] best_age;
    logic [STAMP_W-1:0] age;
    pg       = 0;
    by_evict = 1'b0;
    if (pages_open < MAX_PAGES) begin
      pg = pages_open;
      pages_open++;
      open_fresh(pg, use_s);
      return 1'b1;
    end
    best     = 0;
    best_age = '0;
    for (int i = 0; i < MAX_PAGES; i++) begin
      age = (page_use[i] == use_s) ? '1 : page_use[i];
      if (i == 0 || age < best_age) begin
        best     = i;
        best_age = age;
      end
    end
    if (page_use[best] == use_s) return 1'b0;
    open_fresh(best, use_s);
    pg       = best;
    by_evict = 1'b1;
    return 1'b1;
  endfunction

  function automatic spl_rsp_t locate_rect(input spl_req_t r);
    spl_rsp_t    res;
    int unsigned w;
    int unsigned h;
    int unsigned pg;
    int unsigned px;
    int unsigned py;
    bit          fresh;
    bit          by_evict;
    res      = '0;
    w        = r.rect_width;
    h        = r.rect_height;
    pg       = 0;
    fresh    = 1'b0;
    by_evict = 1'b0;
    if (r.kind == KIND_TOUCH) begin
      if (r.touch_page < pages_open && r.touch_page < MAX_PAGES) begin
        page_use[r.touch_page] = r.use_stamp;
        res.ok         = 1'b1;
        res.page_index = r.touch_page;
      end
      return res;
    end
    if (w == 0 || h == 0 || w > PAGE_SIZE - 2 || h > PAGE_SIZE - 2) return res;
    if (cur_valid && cur_page < pages_open && cur_page < MAX_PAGES) begin
      pg = cur_page;
    end else begin
      if (!claim_page(r.use_stamp, pg, by_evict)) return res;
      fresh = 1'b1;
    end
    // advance to a new shelf; this sticks even if the page change fails
    if (row_x[pg] + w + 1 > PAGE_SIZE) begin
      row_x[pg] = 1;
      row_y[pg] = (row_y[pg] + row_h[pg] + 1) & 32'hFFFF;
      row_h[pg] = 0;
    end
    if (row_y[pg] + h + 1 > PAGE_SIZE) begin
      if (!claim_page(r.use_stamp, pg, by_evict)) return res;
      fresh = 1'b1;
    end
    px        = row_x[pg];
    py        = row_y[pg];
    row_x[pg] = px + w + 1;
    if (h > row_h[pg]) row_h[pg] = h;
    page_use[pg] = r.use_stamp;
    res.ok         = 1'b1;
    res.page_index = TP_W'(pg);
    res.pos_x      = POS_W'(px);
    res.pos_y      = POS_W'(py);
    res.new_page   = fresh;
    res.evicted    = fresh && by_evict;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_atlas();
      slot_q.delete();
      err_total = 0;
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (done_o) begin
        if (slot_q.size() == 0) begin
          $error("result with no request outstanding: %p", rsp_o);
          err_total++;
        end else begin
          want = slot_q.pop_front();
          if (rsp_o.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, rsp_o.ok);
            err_total++;
          end
          if (rsp_o.page_index !== want.page_index) begin
            $error("page_index: expected %0d, got %0d", want.page_index, rsp_o.page_index);
            err_total++;
          end
          if (rsp_o.pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, got %0d", want.pos_x, rsp_o.pos_x);
            err_total++;
          end
          if (rsp_o.pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, got %0d", want.pos_y, rsp_o.pos_y);
            err_total++;
          end
          if (rsp_o.new_page !== want.new_page) begin
            $error("new_page: expected %0d, got %0d", want.new_page, rsp_o.new_page);
            err_total++;
          end
          if (rsp_o.evicted !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, rsp_o.evicted);
            err_total++;
          end
        end
      end
      if (start && !busy) slot_q = {slot_q, locate_rect(req_i)};
      pending    <= slot_q.size();
      fail_count <= err_total;
    end
  end

endmodule

### test/tb_shelf_packer_with_lru_pages.sv
`timescale 1ns / 1ps
// Testbench top for shelf_packer_with_lru_pages: directed and random requests.
// Needs spl_pkg, the block and shelf_packer_checker.
module tb_shelf_packer_with_lru_pages;
  import spl_pkg::*;

  localparam int PAGE_SIZE  = DEF_PAGE_SIZE;
  localparam int MAX_PAGES  = DEF_MAX_PAGES;
  localparam int N_RANDOM   = 700;
  localparam int DRAIN      = MAX_PAGES + 20;
  localparam int LIMIT      = 300000;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  spl_req_t req_i  = '0;
  logic     done_o;
  spl_rsp_t rsp_o;

  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  logic [STAMP_W-1:0] frame_stamp;

  always #5 clk_i = ~clk_i;

  shelf_packer_with_lru_pages #(
    .PAGE_SIZE(PAGE_SIZE),
    .MAX_PAGES(MAX_PAGES)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  shelf_packer_checker #(
    .PAGE_SIZE(PAGE_SIZE),
    .MAX_PAGES(MAX_PAGES)
  ) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic spl_req_t make_req(input spl_kind_e kind, input int w, input int h,
                                        input int tp, input logic [STAMP_W-1:0] use_s);
    spl_req_t r;
    r.kind        = kind;
    r.rect_width  = DIM_W'(w);
    r.rect_height = DIM_W'(h);
    r.touch_page  = TP_W'(tp);
    r.use_stamp   = use_s;
    return r;
  endfunction

  function automatic spl_req_t random_req();
    spl_req_t r;
    int       sel;
    int       s;
    s = $urandom_range(0, 99);
    if (s < 70) begin
    end else if (s < 92) begin
      frame_stamp = frame_stamp + 1;
    end else if (s < 97) begin
      frame_stamp = {$urandom, $urandom};
    end else begin
      frame_stamp = frame_stamp - $urandom_range(1, 5);
    end
    r.kind        = KIND_PLACE;
    r.rect_width  = DIM_W'($urandom);
    r.rect_height = DIM_W'($urandom);
    r.touch_page  = TP_W'($urandom);
    r.use_stamp   = frame_stamp;
    sel = $urandom_range(0, 99);
    if (sel < 14) begin
      r.kind = KIND_TOUCH;
    end else if (sel < 19) begin
      case ($urandom_range(0, 3))
        0:       r.rect_width  = '0;
        1:       r.rect_height = '0;
        2:       r.rect_width  = DIM_W'($urandom_range(PAGE_SIZE - 1, 4095));
        default: r.rect_height = DIM_W'($urandom_range(PAGE_SIZE - 1, 4095));
      endcase
    end else if (sel < 60) begin
      r.rect_width  = DIM_W'($urandom_range(1, 48));
      r.rect_height = DIM_W'($urandom_range(1, 48));
    end else if (sel < 85) begin
      r.rect_width  = DIM_W'($urandom_range(1, 256));
      r.rect_height = DIM_W'($urandom_range(1, 256));
    end else if (sel < 96) begin
      r.rect_width  = DIM_W'($urandom_range(257, PAGE_SIZE - 2));
      r.rect_height = DIM_W'($urandom_range(257, PAGE_SIZE - 2));
    end else begin
      r.rect_width  = DIM_W'($urandom_range(PAGE_SIZE - 24, PAGE_SIZE - 2));
      r.rect_height = DIM_W'($urandom_range(PAGE_SIZE - 24, PAGE_SIZE - 2));
    end
    return r;
  endfunction

  task automatic send_request(input spl_req_t r);
    int gap;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_request(make_req(KIND_TOUCH, 0, 0, 0, 64'd5));
    send_request(make_req(KIND_PLACE, 0, 16, 0, 64'd1));
    send_request(make_req(KIND_PLACE, 10, 0, 0, 64'd1));
    send_request(make_req(KIND_PLACE, PAGE_SIZE - 1, 5, 0, 64'd1));
    send_request(make_req(KIND_PLACE, 5, 4095, 0, 64'd1));
    send_request(make_req(KIND_PLACE, 1, 1, 0, 64'd1));
    send_request(make_req(KIND_PLACE, PAGE_SIZE - 2, 1, 0, 64'd1));
    for (int i = 1; i < MAX_PAGES; i++)
      send_request(make_req(KIND_PLACE, PAGE_SIZE - 2, PAGE_SIZE - 2, 0, 64'(i)));
    send_request(make_req(KIND_PLACE, PAGE_SIZE - 2, PAGE_SIZE - 2, 0, 64'd9));
    send_request(make_req(KIND_PLACE, PAGE_SIZE - 2, PAGE_SIZE - 2, 0, 64'd9));
    for (int i = 0; i < MAX_PAGES; i++)
      send_request(make_req(KIND_TOUCH, 0, 0, i, 64'd100));
    send_request(make_req(KIND_PLACE, PAGE_SIZE - 2, PAGE_SIZE - 2, 0, 64'd100));

    frame_stamp = 64'd200;
    for (int i = 0; i < N_RANDOM; i++) send_request(random_req());
    start <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
